FILE: rtl/pdm_pkg.sv
// Package for the peer delay measurement core: codes, payload structs and
// shared constants. No dependencies.
package pdm_pkg;

  localparam int unsigned MaxDelayNsDefault = 50000;
  localparam int unsigned QueueDepthDefault = 8;

  localparam int unsigned TimeW = 48;
  localparam int unsigned SeqW  = 16;
  localparam int unsigned ClkW  = 64;
  localparam int unsigned PortW = 16;
  localparam int unsigned DlyW  = 15;
  localparam int unsigned CfgW  = 16;
  localparam int unsigned CfgIdxW = 1;

  localparam logic [CfgIdxW-1:0] CFG_REPEAT  = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_TIMEOUT = 1'b1;

  localparam logic [CfgW-1:0] RepeatTicksRst  = 16'd1000;
  localparam logic [CfgW-1:0] TimeoutTicksRst = 16'd1000;

  typedef enum logic [2:0] {
    MODE_TICK    = 3'd0,
    MODE_ENABLE  = 3'd1,
    MODE_PEERREQ = 3'd2,
    MODE_RESP    = 3'd3,
    MODE_FLWUP   = 3'd4,
    MODE_TXTIME  = 3'd5
  } mode_e;

  typedef enum logic [2:0] {
    KIND_REQ   = 3'd0,
    KIND_RESP  = 3'd1,
    KIND_FLWUP = 3'd2,
    KIND_MEAS  = 3'd3,
    KIND_NEG   = 3'd4,
    KIND_LARGE = 3'd5
  } kind_e;

  typedef enum logic [1:0] {
    PH_INIT  = 2'd0,
    PH_IDLE  = 2'd1,
    PH_RESP  = 2'd2,
    PH_FLWUP = 2'd3
  } phase_e;

  // What the control stage hands to the result stage
  typedef enum logic [1:0] {
    EV_NONE = 2'd0,
    EV_REQ  = 2'd1,
    EV_PEER = 2'd2,
    EV_MEAS = 2'd3
  } ev_e;

  typedef struct packed {
    logic [2:0]       mode;
    logic [TimeW-1:0] local_time;
    logic [TimeW-1:0] body_time;
    logic [SeqW-1:0]  seq_id;
    logic [ClkW-1:0]  port_clock_id;
    logic [PortW-1:0] port_number;
  } pdm_in_t;

  typedef struct packed {
    logic [2:0]       kind;
    logic [SeqW-1:0]  out_seq;
    logic [TimeW-1:0] out_time;
    logic [ClkW-1:0]  out_clock_id;
    logic [PortW-1:0] out_port;
    logic [DlyW-1:0]  delay_ns;
    logic             last;
  } pdm_out_t;

  typedef struct packed {
    ev_e              op;
    logic [SeqW-1:0]  seq;
    logic [TimeW-1:0] tm;
    logic [ClkW-1:0]  clk_id;
    logic [PortW-1:0] port;
    logic [TimeW-1:0] d0;   // t4 - t1
    logic [TimeW-1:0] d1;   // t3 - t2
  } ev_t;

  // Number of results an event produces
  function automatic logic [1:0] ev_count(ev_e op);
    logic [1:0] n;
    case (op)
      EV_REQ:  n = 2'd1;
      EV_PEER: n = 2'd2;
      EV_MEAS: n = 2'd1;
      default: n = 2'd0;
    endcase
    return n;
  endfunction

endpackage

FILE: rtl/pdm_ctrl.sv
// Control stage: phase machine, timers, timestamps and config registers.
// Depends on pdm_pkg.
module pdm_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  pdm_pkg::pdm_in_t in_i,
  input  logic             cfg_we_i,
  input  logic [pdm_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [pdm_pkg::CfgW-1:0]    cfg_data_i,
  output pdm_pkg::ev_t     ev_o
);
  import pdm_pkg::*;

  logic [CfgW-1:0]  repeat_ticks_q, timeout_ticks_q;
  phase_e           phase_q, phase_d;
  logic [SeqW-1:0]  rep_cnt_q, rep_cnt_d, to_cnt_q, to_cnt_d, seq_q, seq_d;
  logic [TimeW-1:0] t1_q, t1_d, t2_q, t2_d, t4_q, t4_d, d0_q, d0_d;
  ev_e              op_d, op_q;
  ev_t              rec_d, rec_q;
  mode_e            mode;
  logic [SeqW-1:0]  rep_inc, to_inc;
  logic             is_tick, rep_fire, to_fire, send;

  assign mode     = mode_e'(in_i.mode);
  assign is_tick  = accept_i && (mode == MODE_TICK);
  assign rep_inc  = rep_cnt_q + 16'd1;
  assign to_inc   = to_cnt_q + 16'd1;
  assign rep_fire = rep_inc >= repeat_ticks_q;
  assign to_fire  = to_inc >= timeout_ticks_q;
  assign send     = is_tick && (((phase_q == PH_IDLE) && rep_fire) ||
                                ((phase_q == PH_RESP) && to_fire));

  // next phase
  always_comb begin
    phase_d = phase_q;
    if (send) begin
      phase_d = PH_RESP;
    end else if (accept_i) begin
      case (mode)
        MODE_ENABLE: if (phase_q == PH_INIT)  phase_d = PH_IDLE;
        MODE_RESP:   if (phase_q == PH_RESP)  phase_d = PH_FLWUP;
        MODE_FLWUP:  if (phase_q == PH_FLWUP) phase_d = PH_IDLE;
        default:     phase_d = phase_q;
      endcase
    end
  end

  // counters, timestamps and event record
  always_comb begin
    rep_cnt_d = rep_cnt_q;
    to_cnt_d  = to_cnt_q;
    seq_d     = seq_q;
    t1_d      = t1_q;
    t2_d      = t2_q;
    t4_d      = t4_q;
    d0_d      = d0_q;
    op_d      = EV_NONE;
    rec_d.op     = EV_NONE;
    rec_d.seq    = in_i.seq_id;
    rec_d.tm     = in_i.local_time;
    rec_d.clk_id = in_i.port_clock_id;
    rec_d.port   = in_i.port_number;
    rec_d.d0     = d0_q;
    rec_d.d1     = in_i.body_time - t2_q;
    if (accept_i) begin
      case (mode)
        MODE_TICK: begin
          if (phase_q == PH_IDLE) begin
            rep_cnt_d = rep_fire ? '0 : rep_inc;
          end else if (phase_q == PH_RESP) begin
            to_cnt_d = to_inc;
          end
          if (send) begin
            t1_d      = '0;
            t2_d      = '0;
            t4_d      = '0;
            d0_d      = '0;
            to_cnt_d  = '0;
            rec_d.seq = seq_q;
            seq_d     = seq_q + 16'd1;
            op_d      = EV_REQ;
          end
        end
        MODE_ENABLE: begin
          if (phase_q == PH_INIT) rep_cnt_d = '0;
        end
        MODE_PEERREQ: begin
          if (phase_q != PH_INIT) op_d = EV_PEER;
        end
        MODE_RESP: begin
          if (phase_q == PH_RESP) begin
            t2_d = in_i.body_time;
            t4_d = in_i.local_time;
            d0_d = in_i.local_time - t1_q;
          end
        end
        MODE_FLWUP: begin
          if (phase_q == PH_FLWUP) begin
            op_d      = EV_MEAS;
            rep_cnt_d = '0;
          end
        end
        MODE_TXTIME: begin
          if (phase_q == PH_RESP || phase_q == PH_FLWUP) begin
            t1_d = in_i.local_time;
            d0_d = t4_q - in_i.local_time;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      repeat_ticks_q  <= RepeatTicksRst;
      timeout_ticks_q <= TimeoutTicksRst;
      phase_q   <= PH_INIT;
      rep_cnt_q <= '0;
      to_cnt_q  <= '0;
      seq_q     <= '0;
      t1_q      <= '0;
      t2_q      <= '0;
      t4_q      <= '0;
      d0_q      <= '0;
      op_q      <= EV_NONE;
    end else begin
      if (cfg_we_i && cfg_idx_i == CFG_REPEAT)  repeat_ticks_q  <= cfg_data_i;
      if (cfg_we_i && cfg_idx_i == CFG_TIMEOUT) timeout_ticks_q <= cfg_data_i;
      phase_q   <= phase_d;
      rep_cnt_q <= rep_cnt_d;
      to_cnt_q  <= to_cnt_d;
      seq_q     <= seq_d;
      t1_q      <= t1_d;
      t2_q      <= t2_d;
      t4_q      <= t4_d;
      d0_q      <= d0_d;
      op_q      <= op_d;
    end
  end

  // record payload, no reset needed
  always_ff @(posedge clk_i) begin
    rec_q <= rec_d;
  end

  always_comb begin
    ev_o    = rec_q;
    ev_o.op = op_q;
  end

endmodule

FILE: rtl/pdm_result.sv
// Result stage: turns a registered event into up to two result transactions,
// including the delay subtract and range checks. Depends on pdm_pkg.
module pdm_result #(
  parameter int unsigned MAX_DELAY_NS = pdm_pkg::MaxDelayNsDefault
) (
  input  pdm_pkg::ev_t     ev_i,
  output logic [1:0]       push_n_o,
  output pdm_pkg::pdm_out_t res0_o,
  output pdm_pkg::pdm_out_t res1_o
);
  import pdm_pkg::*;

  logic [TimeW:0]   diff;
  logic             neg, too_big;

  assign diff    = {1'b0, ev_i.d0} - {1'b0, ev_i.d1};
  assign neg     = diff[TimeW];
  assign too_big = diff[TimeW-1:0] > TimeW'(MAX_DELAY_NS);

  assign push_n_o = ev_count(ev_i.op);

  always_comb begin
    res0_o = '0;
    res1_o = '0;
    case (ev_i.op)
      EV_REQ: begin
        res0_o.kind    = KIND_REQ;
        res0_o.out_seq = ev_i.seq;
        res0_o.last    = 1'b1;
      end
      EV_PEER: begin
        res0_o.kind         = KIND_RESP;
        res0_o.out_seq      = ev_i.seq;
        res0_o.out_time     = ev_i.tm;
        res0_o.out_clock_id = ev_i.clk_id;
        res0_o.out_port     = ev_i.port;
        res1_o.kind         = KIND_FLWUP;
        res1_o.out_seq      = ev_i.seq;
        res1_o.out_clock_id = ev_i.clk_id;
        res1_o.out_port     = ev_i.port;
        res1_o.last         = 1'b1;
      end
      EV_MEAS: begin
        res0_o.last = 1'b1;
        if (neg) begin
          res0_o.kind = KIND_NEG;
        end else if (too_big) begin
          res0_o.kind = KIND_LARGE;
        end else begin
          res0_o.kind     = KIND_MEAS;
          res0_o.delay_ns = diff[DlyW:1];  // half round trip
        end
      end
      default: ;
    endcase
  end

endmodule

FILE: rtl/pdm_outq.sv
// Output queue: takes up to two results per cycle, presents one per cycle.
// Depends on pdm_pkg.
module pdm_outq #(
  parameter int unsigned DEPTH = pdm_pkg::QueueDepthDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [1:0]        push_n_i,
  input  pdm_pkg::pdm_out_t res0_i,
  input  pdm_pkg::pdm_out_t res1_i,
  input  logic              pop_i,
  output logic [$clog2(DEPTH+1)-1:0] count_o,
  output pdm_pkg::pdm_out_t head_o
);
  import pdm_pkg::*;

  localparam int unsigned PtrW = $clog2(DEPTH);
  localparam int unsigned CntW = $clog2(DEPTH+1);

  pdm_out_t        mem_q [DEPTH];
  logic [PtrW-1:0] wr_q, rd_q, wr1;
  logic [CntW-1:0] count_q;

  function automatic logic [PtrW-1:0] ptr_inc(logic [PtrW-1:0] p);
    return (p == PtrW'(DEPTH-1)) ? '0 : p + 1'b1;
  endfunction

  assign wr1     = ptr_inc(wr_q);
  assign count_o = count_q;
  assign head_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_n_i != 2'd0) mem_q[wr_q] <= res0_i;
    if (push_n_i == 2'd2) mem_q[wr1]  <= res1_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      if (push_n_i == 2'd1) wr_q <= wr1;
      if (push_n_i == 2'd2) wr_q <= ptr_inc(wr1);
      if (pop_i) rd_q <= ptr_inc(rd_q);
      count_q <= count_q + CntW'(push_n_i) - CntW'(pop_i);
    end
  end

endmodule

FILE: rtl/peer_delay_measurement_core.sv
// Top level of the peer delay measurement core: control stage, result stage
// and output queue. Depends on pdm_pkg, pdm_ctrl, pdm_result, pdm_outq.
//
//   channel | direction | handshake                | payload
//   --------+-----------+--------------------------+------------
//   in      | into core | in_valid_i / in_stall_o  | pdm_in_t
//   out     | from core | out_valid_o / out_stall_i| pdm_out_t
//   cfg     | into core | cfg_we_i, cfg_idx_i      | cfg_data_i
//
// One input transaction per cycle while in_stall_o is low. An accepted item
// updates phase, timers and timestamps at that edge and is registered as an
// event; its results are built from that event in the next cycle and written
// into the output queue at the end of that cycle.
// A peer request yields two results, so the output side drains at most one
// per cycle and sets the long-run rate for request bursts.
// in_stall_o rises only when the queue might not have room for the results
// of the item in the result stage plus two more.
// Reset (async, active low) returns to the init phase with empty queue and
// config registers at 1000 ticks each.
module peer_delay_measurement_core #(
  parameter int unsigned MAX_DELAY_NS = pdm_pkg::MaxDelayNsDefault,
  parameter int unsigned QUEUE_DEPTH  = pdm_pkg::QueueDepthDefault
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  pdm_pkg::pdm_in_t            in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output pdm_pkg::pdm_out_t           out_data_o,
  input  logic                        cfg_we_i,
  input  logic [pdm_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [pdm_pkg::CfgW-1:0]    cfg_data_i
);
  import pdm_pkg::*;

  localparam int unsigned CntW = $clog2(QUEUE_DEPTH+1);
  localparam int unsigned SumW = CntW + 1;

  ev_t             ev;
  logic [1:0]      push_n;
  pdm_out_t        res0, res1;
  logic [CntW-1:0] count;
  logic [SumW-1:0] need;
  logic            accept, pop;

  // worst case fill after the staged event and one more item
  assign need       = SumW'(count) + SumW'(push_n) + SumW'(2);
  assign in_stall_o = need > SumW'(QUEUE_DEPTH);
  assign accept     = in_valid_i && !in_stall_o;

  assign out_valid_o = count != '0;
  assign pop         = out_valid_o && !out_stall_i;

  pdm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .in_i       (in_data_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .ev_o       (ev)
  );

  pdm_result #(
    .MAX_DELAY_NS (MAX_DELAY_NS)
  ) u_result (
    .ev_i     (ev),
    .push_n_o (push_n),
    .res0_o   (res0),
    .res1_o   (res1)
  );

  pdm_outq #(
    .DEPTH (QUEUE_DEPTH)
  ) u_outq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_n_i (push_n),
    .res0_i   (res0),
    .res1_i   (res1),
    .pop_i    (pop),
    .count_o  (count),
    .head_o   (out_data_o)
  );

endmodule

FILE: rtl/pdm_checker.sv
// Port-level checker for the peer delay measurement core, with its bind.
// Depends on pdm_pkg and peer_delay_measurement_core.
module pdm_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input pdm_pkg::pdm_out_t out_data_o
);
  import pdm_pkg::*;

  // a pending result waits until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output transaction dropped while stalled");

  // a response always comes straight after with its follow-up
  a_resp_flwup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && out_data_o.kind == KIND_RESP |=>
      out_valid_o && out_data_o.kind == KIND_FLWUP &&
      out_data_o.out_seq == $past(out_data_o.out_seq))
    else $error("response not followed by its follow-up");

  // only a response is a non-last result
  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.kind != KIND_RESP |-> out_data_o.last)
    else $error("non-response result without last");

endmodule

bind peer_delay_measurement_core pdm_checker u_pdm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

FILE: test/peer_delay_measurement_core_tb.sv
`timescale 1ns / 100ps
// Testbench for peer_delay_measurement_core: directed and random peer delay
// traffic, every result checked against an in-bench model of the state machine.
// Depends on pdm_pkg and the core RTL.
module peer_delay_measurement_core_tb;
  import pdm_pkg::*;

  // mode codes the block must drop
  localparam logic [2:0] MODE_RSVD6 = 3'd6;
  localparam logic [2:0] MODE_RSVD7 = 3'd7;

  localparam int unsigned RandItems    = 1350;
  localparam int unsigned CfgEvery     = 150;  // items between register changes
  localparam int unsigned SettleCycles = 8;    // pipeline depth plus margin
  localparam logic [CfgW-1:0] CfgMax   = '1;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  pdm_in_t             in_data;
  logic                out_valid;
  logic                out_stall;
  pdm_out_t            out_data;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [CfgW-1:0]     cfg_data;

  // Link model: phase, timers, sequence number and the three stored stamps
  phase_e              m_phase;
  logic [SeqW-1:0]     m_rpt_cnt;
  logic [SeqW-1:0]     m_tmo_cnt;
  logic [SeqW-1:0]     m_next_seq;
  logic [CfgW-1:0]     m_rpt_ticks;
  logic [CfgW-1:0]     m_tmo_ticks;
  logic [TimeW-1:0]    m_t1;
  logic [TimeW-1:0]    m_t2;
  logic [TimeW-1:0]    m_t4;

  pdm_out_t            pending_results[$];
  int                  err_count;
  int                  useful_items;   // transactions that moved the model
  bit                  calm;           // no idling on either side while set

  peer_delay_measurement_core dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data)
  );

  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Link model
  // ---------------------------------------------------------------------------
  function automatic pdm_out_t make_result(kind_e k, logic [SeqW-1:0] seq,
                                           logic [TimeW-1:0] tm, logic [ClkW-1:0] cid,
                                           logic [PortW-1:0] port, logic [DlyW-1:0] dly,
                                           logic fin);
    pdm_out_t r;
    r.kind         = k;
    r.out_seq      = seq;
    r.out_time     = tm;
    r.out_clock_id = cid;
    r.out_port     = port;
    r.delay_ns     = dly;
    r.last         = fin;
    return r;
  endfunction

  // New or repeated request: stamps cleared, timeout restarts
  function automatic void issue_request();
    m_t1 = '0;
    m_t2 = '0;
    m_t4 = '0;
    pending_results.push_back(make_result(KIND_REQ, m_next_seq, '0, '0, '0, '0, 1'b1));
    m_next_seq = m_next_seq + 1'b1;
    m_tmo_cnt  = '0;
    m_phase    = PH_RESP;
  endfunction

  // Applies one accepted transaction; returns 1 unless the block drops it
  function automatic bit predict_pdelay(pdm_in_t it);
    logic [TimeW-1:0] d0;
    logic [TimeW-1:0] d1;
    logic [TimeW-1:0] rt;
    bit acted;
    acted = 1'b0;
    case (it.mode)
      MODE_TICK: begin
        if (m_phase == PH_IDLE) begin
          acted     = 1'b1;
          m_rpt_cnt = m_rpt_cnt + 1'b1;
          if (m_rpt_cnt >= m_rpt_ticks) begin
            m_rpt_cnt = '0;
            issue_request();
          end
        end else if (m_phase == PH_RESP) begin
          acted     = 1'b1;
          m_tmo_cnt = m_tmo_cnt + 1'b1;
          if (m_tmo_cnt >= m_tmo_ticks) issue_request();
        end
      end
      MODE_ENABLE: begin
        if (m_phase == PH_INIT) begin
          acted     = 1'b1;
          m_phase   = PH_IDLE;
          m_rpt_cnt = '0;
        end
      end
      MODE_PEERREQ: begin
        // answered in every phase but init: response, then follow-up
        if (m_phase != PH_INIT) begin
          acted = 1'b1;
          pending_results.push_back(make_result(KIND_RESP, it.seq_id, it.local_time,
                                                it.port_clock_id, it.port_number, '0, 1'b0));
          pending_results.push_back(make_result(KIND_FLWUP, it.seq_id, '0,
                                                it.port_clock_id, it.port_number, '0, 1'b1));
        end
      end
      MODE_RESP: begin
        if (m_phase == PH_RESP) begin
          acted   = 1'b1;
          m_t2    = it.body_time;
          m_t4    = it.local_time;
          m_phase = PH_FLWUP;
        end
      end
      MODE_FLWUP: begin
        if (m_phase == PH_FLWUP) begin
          acted = 1'b1;
          d0    = m_t4 - m_t1;          // modulo 2^48
          d1    = it.body_time - m_t2;
          if (d1 > d0) begin
            pending_results.push_back(make_result(KIND_NEG, '0, '0, '0, '0, '0, 1'b1));
          end else begin
            rt = d0 - d1;
            if (rt > TimeW'(MaxDelayNsDefault))
              pending_results.push_back(make_result(KIND_LARGE, '0, '0, '0, '0, '0, 1'b1));
            else
              pending_results.push_back(make_result(KIND_MEAS, '0, '0, '0, '0,
                                                    rt[DlyW:1], 1'b1));
          end
          m_phase   = PH_IDLE;
          m_rpt_cnt = '0;
        end
      end
      MODE_TXTIME: begin
        if (m_phase == PH_RESP || m_phase == PH_FLWUP) begin
          acted = 1'b1;
          m_t1  = it.local_time;
        end
      end
      default: ;
    endcase
    return acted;
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking: a transaction is taken at the rising edge after a falling
  // edge that sees valid high and stall low; both are stable in between.
  // ---------------------------------------------------------------------------
  task automatic check_result(input pdm_out_t got);
    pdm_out_t want;
    if (pending_results.size() == 0) begin
      if (err_count < 10)
        $display("unexpected result: kind %0d seq %h delay %0d",
                 got.kind, got.out_seq, got.delay_ns);
      err_count++;
    end else begin
      want = pending_results.pop_front();
      if (got.kind !== want.kind || got.out_seq !== want.out_seq ||
          got.out_time !== want.out_time || got.out_clock_id !== want.out_clock_id ||
          got.out_port !== want.out_port || got.delay_ns !== want.delay_ns ||
          got.last !== want.last) begin
        if (err_count < 10) begin
          $display("result mismatch at %0t (expected / actual):", $realtime);
          $display("  kind %0d / %0d  seq %h / %h  time %h / %h",
                   want.kind, got.kind, want.out_seq, got.out_seq,
                   want.out_time, got.out_time);
          $display("  clock id %h / %h  port %h / %h  delay %0d / %0d  last %b / %b",
                   want.out_clock_id, got.out_clock_id, want.out_port, got.out_port,
                   want.delay_ns, got.delay_ns, want.last, got.last);
        end
        err_count++;
      end
    end
  endtask

  always @(negedge clk) begin
    if (rst_n && out_valid && !out_stall) check_result(out_data);
  end

  // receiver back-pressure at random, with a chance of 7 in 100
  always @(posedge clk) begin
    out_stall <= !calm && ($urandom_range(99) < 7);
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic logic [TimeW-1:0] rand48();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[TimeW-1:0];
  endfunction

  function automatic pdm_in_t rand_item(logic [2:0] m);
    pdm_in_t it;
    it.mode          = m;
    it.local_time    = rand48();
    it.body_time     = rand48();
    it.seq_id        = SeqW'($urandom);
    it.port_clock_id = {$urandom, $urandom};
    it.port_number   = PortW'($urandom);
    return it;
  endfunction

  // Presents one transaction, holds it until taken, then updates the model.
  // Valid stays high on return so back-to-back items leave no idle gap.
  task automatic send_item(input pdm_in_t it);
    if (!calm && $urandom_range(99) < 7) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(negedge clk);
    while (in_stall) @(negedge clk);
    @(posedge clk);
    if (predict_pdelay(it)) useful_items++;
  endtask

  task automatic send_mode(input logic [2:0] m);
    send_item(rand_item(m));
  endtask

  task automatic send_times(input logic [2:0] m, input logic [TimeW-1:0] lt,
                            input logic [TimeW-1:0] bt);
    pdm_in_t it;
    it            = rand_item(m);
    it.local_time = lt;
    it.body_time  = bt;
    send_item(it);
  endtask

  // Stops sending and waits out every outstanding result plus the pipeline
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  // Only called with the block idle
  task automatic set_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] val);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (idx == CFG_REPEAT) m_rpt_ticks = val;
    else m_tmo_ticks = val;
  endtask

  // Occasional interloper inside an exchange
  task automatic stray_item();
    if ($urandom_range(3) == 0) begin
      case ($urandom_range(4))
        0, 1:    send_mode(MODE_PEERREQ);
        2:       send_mode(MODE_TICK);
        3:       send_mode(MODE_ENABLE);
        default: send_mode(3'($urandom_range(7)));
      endcase
    end
  endtask

  // One measurement: ticks up to a request, then t1, response (t2, t4 = t1+d0)
  // and follow-up (t3 = t2+d1). The model follows whatever really happens.
  task automatic exchange(input logic [TimeW-1:0] t1, input logic [TimeW-1:0] t2,
                          input logic [TimeW-1:0] d0, input logic [TimeW-1:0] d1,
                          input bit messy);
    logic [SeqW-1:0] seq0;
    while (m_phase != PH_RESP) begin
      case (m_phase)
        PH_INIT:  send_mode(MODE_ENABLE);
        PH_FLWUP: send_mode(MODE_FLWUP);
        default:  send_mode(MODE_TICK);
      endcase
      if (messy) stray_item();
    end
    // sometimes let the response time out so the request goes out again
    if (messy && m_tmo_ticks <= 12 && $urandom_range(7) == 0) begin
      seq0 = m_next_seq;
      while (m_phase == PH_RESP && m_next_seq == seq0) send_mode(MODE_TICK);
    end
    send_times(MODE_TXTIME, t1, rand48());
    if (messy) stray_item();
    send_times(MODE_RESP, t1 + d0, t2);
    if (messy) stray_item();
    send_times(MODE_FLWUP, rand48(), t2 + d1);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Before enable every transaction is dropped; a second enable is dropped too
  task automatic test_init_phase();
    send_mode(MODE_TICK);
    send_mode(MODE_PEERREQ);
    send_mode(MODE_RESP);
    send_mode(MODE_FLWUP);
    send_mode(MODE_TXTIME);
    send_mode(MODE_RSVD6);
    send_mode(MODE_RSVD7);
    send_mode(MODE_ENABLE);
    send_mode(MODE_ENABLE);
  endtask

  // Peer requests with every field at zero and at all ones, then a random one
  task automatic test_peer_requests();
    pdm_in_t it;
    it      = '0;
    it.mode = MODE_PEERREQ;
    send_item(it);
    it      = '1;
    it.mode = MODE_PEERREQ;
    send_item(it);
    send_mode(MODE_PEERREQ);
  endtask

  task automatic test_delay_results();
    drain_results();
    set_reg(CFG_REPEAT, 16'd1);
    set_reg(CFG_TIMEOUT, 16'd2);
    exchange('0, '0, '0, '0, 1'b0);                                      // zero delay
    exchange('1, '1, TimeW'(MaxDelayNsDefault), '0, 1'b0);               // limit, wrapping t4
    exchange(rand48(), rand48(), TimeW'(MaxDelayNsDefault + 1), '0, 1'b0); // just too large
    exchange(rand48(), rand48(), 48'd1000, 48'd1001, 1'b0);              // negative by one
    exchange(rand48(), rand48(), '1, '1 - 48'd2, 1'b0);                  // huge spans, delay 1
    // request, one tick short of the timeout, resend, count restarts
    send_mode(MODE_TICK);
    send_mode(MODE_TICK);
    send_mode(MODE_TICK);
    send_mode(MODE_TICK);
    send_mode(MODE_FLWUP);                 // not expected yet: dropped
    send_times(MODE_TXTIME, rand48(), '0);
    send_times(MODE_RESP, 48'd1100, '0);
    send_times(MODE_TXTIME, 48'd1000, '0); // t1 still taken while awaiting follow-up
    send_mode(MODE_TICK);                  // no timer runs here
    send_times(MODE_FLWUP, rand48(), '0);  // round trip 100
    send_mode(MODE_TXTIME);                // idle: dropped
    send_mode(MODE_RESP);                  // idle: dropped
  endtask

  // Registers at their maximum, then lowered under a running count
  task automatic test_timer_limits();
    drain_results();
    set_reg(CFG_REPEAT, CfgMax);
    set_reg(CFG_TIMEOUT, CfgMax);
    repeat (10) send_mode(MODE_TICK);
    drain_results();
    set_reg(CFG_REPEAT, 16'd3);
    send_mode(MODE_TICK);                  // fires at once
    repeat (5) send_mode(MODE_TICK);
    drain_results();
    set_reg(CFG_TIMEOUT, 16'd1);
    send_mode(MODE_TICK);                  // resend
    send_mode(MODE_TICK);                  // and again
    exchange(rand48(), rand48(), 48'd777, 48'd3, 1'b0);
  endtask

  // Mostly well-formed exchanges with random stamps and interlopers, plus
  // bare peer requests and noise; registers change every so often.
  task automatic test_random_traffic();
    int next_cfg;
    int pick;
    logic [TimeW-1:0] d0;
    logic [TimeW-1:0] d1;
    next_cfg     = 0;
    useful_items = 0;
    while (useful_items < RandItems) begin
      if (useful_items >= next_cfg) begin
        drain_results();
        set_reg(CFG_REPEAT, CfgW'(($urandom_range(9) == 0) ? $urandom_range(40, 1)
                                                           : $urandom_range(6, 1)));
        set_reg(CFG_TIMEOUT, CfgW'(($urandom_range(9) == 0) ? $urandom_range(65535, 13)
                                                            : $urandom_range(8, 1)));
        next_cfg = useful_items + CfgEvery;
      end
      calm = (useful_items > 500 && useful_items < 800);
      pick = $urandom_range(19);
      if (pick < 14) begin
        d1 = ($urandom_range(3) == 0) ? rand48() : TimeW'($urandom_range(1 << 20));
        case ($urandom_range(9))
          0, 1, 2, 3, 4: d0 = d1 + $urandom_range(MaxDelayNsDefault);
          5, 6:          d0 = ($urandom_range(3) == 0) ? rand48() :
                              d1 + MaxDelayNsDefault + $urandom_range(1 << 20, 1);
          7:             d0 = d1 - $urandom_range(5000, 1);
          default:       d0 = d1 + (($urandom_range(1) == 1) ?
                              MaxDelayNsDefault - 1 + $urandom_range(2) :
                              $urandom_range(1));
        endcase
        exchange(rand48(), rand48(), d0, d1, $urandom_range(1) == 1);
      end else if (pick < 17) begin
        send_mode(MODE_PEERREQ);
      end else begin
        send_mode(3'($urandom_range(7)));
      end
    end
    calm = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_data     = '0;
    out_stall   = 1'b0;
    cfg_we      = 1'b0;
    cfg_idx     = '0;
    cfg_data    = '0;
    calm        = 1'b0;
    err_count   = 0;
    m_phase     = PH_INIT;
    m_rpt_cnt   = '0;
    m_tmo_cnt   = '0;
    m_next_seq  = '0;
    m_rpt_ticks = RepeatTicksRst;
    m_tmo_ticks = TimeoutTicksRst;
    m_t1        = '0;
    m_t2        = '0;
    m_t4        = '0;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_init_phase();
    test_peer_requests();
    test_delay_results();
    test_timer_limits();
    test_random_traffic();

    drain_results();
    if (pending_results.size() != 0) err_count++;
    if (err_count == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

  // hang guard, far beyond the slowest legal run
  initial begin
    #2000000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
